// File: src/kfc_pkg.sv
package kfc_pkg;

	localparam int KEYWORD_SLOTS  = 4;
	localparam int MAX_WORD_BYTES = 8;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 4;
	localparam int SLOT_W     = 2;
	localparam int COUNT_W    = 24;
	localparam int KW_W       = 64;
	localparam int LENGTHS_W  = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int BUF_IDX_W  = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;

	localparam logic [BYTE_W-1:0]  SPACE_CHAR   = 8'd32;
	localparam logic [BYTE_W-1:0]  NEWLINE_CHAR = 8'd10;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

	localparam logic [CFG_INDEX_W-1:0] REG_KW_A    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KW_B    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KW_C    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_KW_D    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_LENGTHS = 3'd4;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// One closed word as it travels from the classifier to the counters.
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              eot;
	} kfc_entry_t;

endpackage

// File: src/kfc_front.sv
module kfc_front
	import kfc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   text_valid,
	output logic                   text_stall,
	input  logic [BYTE_W-1:0]      text_byte,
	input  logic                   end_of_text,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [KW_W-1:0]        cfg_data,
	input  logic                   queue_full,
	output logic                   push,
	output kfc_entry_t             push_entry
);

	logic [KW_W-1:0]      keyword_q [KEYWORD_SLOTS];
	logic [LENGTHS_W-1:0] lengths_q;
	logic [BYTE_W-1:0]    word_q [MAX_WORD_BYTES];
	logic [LEN_W-1:0]     word_len_q;
	logic                 too_long_q;

	logic                     accept;
	logic                     closing;
	logic [KEYWORD_SLOTS-1:0] slot_hit;
	logic                     any_hit;
	logic [SLOT_W-1:0]        hit_slot;

	assign text_stall = queue_full;
	assign accept     = text_valid && !text_stall;
	assign closing    = end_of_text || text_byte == SPACE_CHAR || text_byte == NEWLINE_CHAR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < KEYWORD_SLOTS; s++) keyword_q[s] <= '0;
			lengths_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KW_A:    if (KEYWORD_SLOTS > 0) keyword_q[0] <= cfg_data;
				REG_KW_B:    if (KEYWORD_SLOTS > 1) keyword_q[1 % KEYWORD_SLOTS] <= cfg_data;
				REG_KW_C:    if (KEYWORD_SLOTS > 2) keyword_q[2 % KEYWORD_SLOTS] <= cfg_data;
				REG_KW_D:    if (KEYWORD_SLOTS > 3) keyword_q[3 % KEYWORD_SLOTS] <= cfg_data;
				REG_LENGTHS: lengths_q <= cfg_data[LENGTHS_W-1:0];
				default:     ;
			endcase
		end
	end

	// Each slot compares the finished word byte for byte; only bytes below the
	// keyword length count, and those have all been written.
	always_comb begin
		logic [LEN_W-1:0] klen;
		logic             ok;
		for (int s = 0; s < KEYWORD_SLOTS; s++) begin
			klen = lengths_q[LEN_W*s +: LEN_W];
			ok = klen != '0 && klen <= LEN_W'(MAX_WORD_BYTES) && klen == word_len_q
				&& !too_long_q;
			for (int i = 0; i < MAX_WORD_BYTES; i++) begin
				if (LEN_W'(i) < klen && keyword_q[s][BYTE_W*i +: BYTE_W] != word_q[i])
					ok = 1'b0;
			end
			slot_hit[s] = ok;
		end
	end

	always_comb begin
		any_hit  = 1'b0;
		hit_slot = '0;
		for (int s = KEYWORD_SLOTS - 1; s >= 0; s--) begin
			if (slot_hit[s]) begin
				any_hit  = 1'b1;
				hit_slot = SLOT_W'(s);
			end
		end
	end

	assign push            = accept && closing && (any_hit || end_of_text);
	assign push_entry.hit  = any_hit;
	assign push_entry.slot = hit_slot;
	assign push_entry.eot  = end_of_text;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_len_q <= '0;
			too_long_q <= 1'b0;
		end else if (accept) begin
			if (closing) begin
				word_len_q <= '0;
				too_long_q <= 1'b0;
			end else if (word_len_q < LEN_W'(MAX_WORD_BYTES)) begin
				word_len_q <= word_len_q + 1'b1;
			end else begin
				too_long_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !closing && word_len_q < LEN_W'(MAX_WORD_BYTES))
			word_q[word_len_q[BUF_IDX_W-1:0]] <= text_byte;
	end

endmodule

// File: src/kfc_queue.sv
module kfc_queue
	import kfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  kfc_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output kfc_entry_t pop_entry
);

	kfc_entry_t        slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_entry;
	end

endmodule

// File: src/kfc_back.sv
module kfc_back
	import kfc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               not_empty,
	input  kfc_entry_t         pop_entry,
	output logic               pop,
	output logic               match_valid,
	input  logic               match_stall,
	output logic [SLOT_W-1:0]  keyword_index,
	output logic [COUNT_W-1:0] keyword_count
);

	logic [COUNT_W-1:0] counter_q [KEYWORD_SLOTS];
	logic               out_valid_q;
	logic [SLOT_W-1:0]  index_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] cur;
	logic [COUNT_W-1:0] next_count;

	// The output register is free when empty or when its result transfers now.
	assign pop = not_empty && (!out_valid_q || !match_stall);

	always_comb begin
		cur = '0;
		for (int s = 0; s < KEYWORD_SLOTS; s++) begin
			if (pop_entry.slot == SLOT_W'(s)) cur = counter_q[s];
		end
		next_count = (cur == COUNT_MAX) ? cur : cur + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < KEYWORD_SLOTS; s++) counter_q[s] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && pop_entry.eot) begin
				for (int s = 0; s < KEYWORD_SLOTS; s++) counter_q[s] <= '0;
			end else if (pop && pop_entry.hit) begin
				for (int s = 0; s < KEYWORD_SLOTS; s++) begin
					if (pop_entry.slot == SLOT_W'(s)) counter_q[s] <= next_count;
				end
			end
			if (pop && pop_entry.hit) out_valid_q <= 1'b1;
			else if (!match_stall)    out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_entry.hit) begin
			index_q <= pop_entry.slot;
			count_q <= next_count;
		end
	end

	assign match_valid   = out_valid_q;
	assign keyword_index = index_q;
	assign keyword_count = count_q;

endmodule

// File: src/keyword_frequency_counter.sv
// Whole-word keyword counter for a byte stream.
// Text channel: text_byte with end_of_text, transferred when text_valid is high
// and text_stall is low. Space and newline close a word; end_of_text closes the
// pending word and then clears every counter, whatever text_byte holds.
// Match channel: keyword_index and keyword_count, one result for each closed
// word that equals an enabled keyword (lowest slot wins). Counters saturate.
// Configuration: cfg_index selects keyword text a to d (0 to 3) or the packed
// lengths (4); cfg_ready is always high, and other indexes are ignored.
// Throughput is one byte per cycle while text_stall is low. A result for the
// word closed by a transferred byte passes through the queue to the output
// register. The classifier compares the word against all keywords at once in
// the cycle of that transfer and writes the four-entry queue; the counter stage
// takes the entry once the output register is free and loads that register.
// When the receiver stalls, the result holds, the queue fills with matching
// words and end-of-text markers, and text_stall rises only once it is full.
// Reset clears the word state, all counters, the keyword settings, the output flag and the queue.
module keyword_frequency_counter
	import kfc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   text_valid,
	output logic                   text_stall,
	input  logic [BYTE_W-1:0]      text_byte,
	input  logic                   end_of_text,
	output logic                   match_valid,
	input  logic                   match_stall,
	output logic [SLOT_W-1:0]      keyword_index,
	output logic [COUNT_W-1:0]     keyword_count,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [KW_W-1:0]        cfg_data
);

	logic       queue_full;
	logic       push;
	kfc_entry_t push_entry;
	logic       pop;
	logic       not_empty;
	kfc_entry_t pop_entry;

	assign cfg_ready = 1'b1;

	kfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	kfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_entry (pop_entry)
	);

	kfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.not_empty    (not_empty),
		.pop_entry    (pop_entry),
		.pop          (pop),
		.match_valid  (match_valid),
		.match_stall  (match_stall),
		.keyword_index(keyword_index),
		.keyword_count(keyword_count)
	);

endmodule

// File: dv/keyword_frequency_counter_tb.sv
module keyword_frequency_counter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kfc_pkg::*;

	localparam int CYCLE_LIMIT     = 400_000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_CYCLES     = 300;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int HOLD_PHASE      = 3;
	localparam int PAUSE_PHASE     = 5;
	localparam int QUIET_PHASE     = 6;

	localparam logic [CFG_INDEX_W-1:0] REG_NONE_FIRST = REG_LENGTHS + 1'b1;
	localparam logic [CFG_INDEX_W-1:0] REG_NONE_LAST  = '1;
	localparam logic [SLOT_W-1:0]      SLOT_A         = 2'd0;
	localparam logic [SLOT_W-1:0]      SLOT_B         = 2'd1;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] count;
	} tally_t;

	typedef enum bit {ROW_PREDICTED, ROW_TYPED} row_kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              eot;
		row_kind_t         kind;
		logic              hit;
		tally_t            want;
	} text_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   text_valid = 1'b0;
	logic                   text_stall;
	logic [BYTE_W-1:0]      text_byte = '0;
	logic                   end_of_text = 1'b0;
	logic                   match_valid;
	logic                   match_stall = 1'b0;
	logic [SLOT_W-1:0]      keyword_index;
	logic [COUNT_W-1:0]     keyword_count;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [KW_W-1:0]        cfg_data = '0;

	// Shadow of the block: keyword registers, the word being built and the counters.
	logic [KW_W-1:0]      kw_text [KEYWORD_SLOTS] = '{default: '0};
	logic [LENGTHS_W-1:0] kw_lengths = '0;
	logic [BYTE_W-1:0]    word_buf [MAX_WORD_BYTES] = '{default: '0};
	logic [LEN_W-1:0]     word_len = '0;
	logic                 word_long = 1'b0;
	logic [COUNT_W-1:0]   keyword_tallies [KEYWORD_SLOTS] = '{default: '0};

	tally_t      expected_tallies [$];
	text_row_t   directed_rows [30];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned phase_items = 0;
	bit          quiet_sender = 1'b0;
	bit          quiet_receiver = 1'b0;
	bit          hold_request = 1'b0;
	bit          stall_on = 1'b0;
	int unsigned stall_left = 0;

	keyword_frequency_counter dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int unsigned idle_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	function automatic bit keyword_equals(input int slot);
		logic [LEN_W-1:0] klen;
		klen = kw_lengths[4*slot +: 4];
		if (klen == 0 || klen > MAX_WORD_BYTES || klen != word_len)
			return 1'b0;
		for (int i = 0; i < klen; i++)
			if (kw_text[slot][8*i +: 8] != word_buf[i])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic close_word(output bit hit, output tally_t tally);
		hit = 1'b0;
		tally = '0;
		if (word_len != 0 && !word_long) begin
			// Lowest matching slot takes the word.
			for (int s = 0; s < KEYWORD_SLOTS; s++) begin
				if (!hit && keyword_equals(s)) begin
					if (keyword_tallies[s] != COUNT_MAX)
						keyword_tallies[s]++;
					hit = 1'b1;
					tally.slot = SLOT_W'(s);
					tally.count = keyword_tallies[s];
				end
			end
		end
		word_len = '0;
		word_long = 1'b0;
	endtask

	task automatic scan_byte(input logic [BYTE_W-1:0] ch, input logic eot,
			output bit hit, output tally_t tally);
		if (eot) begin
			close_word(hit, tally);
			foreach (keyword_tallies[s])
				keyword_tallies[s] = '0;
		end else if (ch == SPACE_CHAR || ch == NEWLINE_CHAR) begin
			close_word(hit, tally);
		end else begin
			hit = 1'b0;
			tally = '0;
			if (word_len < MAX_WORD_BYTES) begin
				word_buf[word_len] = ch;
				word_len++;
			end else begin
				word_long = 1'b1;
			end
		end
	endtask

	// Called just after a rising edge; returns at the edge of the transfer.
	task automatic send_byte(input logic [BYTE_W-1:0] ch, input logic eot);
		text_valid <= 1'b1;
		text_byte <= ch;
		end_of_text <= eot;
		do
			@(posedge clk);
		while (text_stall);
	endtask

	task automatic sender_gap();
		int unsigned gap;
		gap = quiet_sender ? 0 : idle_cycles();
		if (gap != 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_scanned(input logic [BYTE_W-1:0] ch, input logic eot);
		bit     hit;
		tally_t tally;
		send_byte(ch, eot);
		scan_byte(ch, eot, hit, tally);
		if (hit)
			expected_tallies.insert(expected_tallies.size(), tally);
		phase_items++;
		sender_gap();
	endtask

	task automatic wait_drained();
		text_valid <= 1'b0;
		while (expected_tallies.size() != 0)
			@(posedge clk);
		// Words that match nothing may still be in the pipeline.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index, input logic [KW_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (index)
			REG_KW_A: kw_text[0] = data;
			REG_KW_B: kw_text[1] = data;
			REG_KW_C: kw_text[2] = data;
			REG_KW_D: kw_text[3] = data;
			REG_LENGTHS: kw_lengths = data[LENGTHS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_keywords(input int phase);
		logic [KW_W-1:0]      texts [KEYWORD_SLOTS];
		logic [LENGTHS_W-1:0] lens;
		logic [BYTE_W-1:0]    b;
		int unsigned          r;
		case (phase)
			0: begin
				texts = '{default: '1};
				lens = '0;
			end
			1: begin
				foreach (texts[s])
					texts[s] = {$urandom, $urandom};
				lens = '1;
			end
			2: begin
				texts = '{'0, '1, '1, '0};
				lens = 16'h8888;
			end
			default: begin
				for (int s = 0; s < KEYWORD_SLOTS; s++) begin
					if (s > 0 && $urandom_range(0, 4) == 0) begin
						// Duplicate the slot below so that the lower one wins.
						texts[s] = texts[s-1];
						lens[4*s +: 4] = lens[4*(s-1) +: 4];
					end else begin
						for (int i = 0; i < 8; i++) begin
							b = BYTE_W'($urandom_range(0, 255));
							if (b == SPACE_CHAR || b == NEWLINE_CHAR)
								b = b ^ 8'h40;
							texts[s][8*i +: 8] = b;
						end
						r = $urandom_range(0, 9);
						if (r == 0)
							lens[4*s +: 4] = '0;
						else if (r == 1)
							lens[4*s +: 4] = LEN_W'($urandom_range(MAX_WORD_BYTES + 1, 15));
						else if (r == 2)
							lens[4*s +: 4] = LEN_W'(MAX_WORD_BYTES);
						else
							lens[4*s +: 4] = LEN_W'($urandom_range(1, MAX_WORD_BYTES));
					end
				end
			end
		endcase
		cfg_write(REG_KW_A, texts[0]);
		cfg_write(REG_KW_B, texts[1]);
		cfg_write(REG_KW_C, texts[2]);
		cfg_write(REG_KW_D, texts[3]);
		cfg_write(REG_LENGTHS, KW_W'(lens));
		cfg_write(CFG_INDEX_W'($urandom_range(REG_NONE_FIRST, REG_NONE_LAST)),
			{$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stalls, a quiet mode, and one long hold on request.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			stall_on = 1'b1;
			stall_left = HOLD_CYCLES;
		end else if (stall_left != 0) begin
			stall_left--;
		end else if (quiet_receiver) begin
			stall_on = 1'b0;
		end else begin
			stall_on = ($urandom_range(0, 2) == 0);
			stall_left = idle_cycles();
		end
		match_stall <= stall_on;
	end

	always @(posedge clk) begin : match_check
		tally_t want;
		if (arst_n && match_valid && !match_stall) begin
			if (expected_tallies.size() == 0) begin
				report_mismatch($sformatf("unexpected match slot %0d count %0d",
					keyword_index, keyword_count));
			end else begin
				want = expected_tallies.pop_front();
				if (keyword_index != want.slot)
					report_mismatch($sformatf("keyword_index %0d, expected %0d",
						keyword_index, want.slot));
				if (keyword_count != want.count)
					report_mismatch($sformatf("keyword_count %0d, expected %0d",
						keyword_count, want.count));
			end
		end
	end

	initial begin
		bit                hit;
		bit                paused;
		tally_t            tally;
		logic [BYTE_W-1:0] word [$];
		int unsigned       pick;
		int unsigned       slot;
		int unsigned       n;
		int unsigned       pos;
		logic [LEN_W-1:0]  klen;

		// Keyword a and c are both "cat"; b uses the byte extremes over the full
		// eight characters; d is longer than any word can be.
		directed_rows = '{
			'{SPACE_CHAR,   1'b0, ROW_TYPED,     1'b0, '0},
			'{NEWLINE_CHAR, 1'b0, ROW_TYPED,     1'b0, '0},
			'{"c",          1'b0, ROW_PREDICTED, 1'b0, '0},
			'{"a",          1'b0, ROW_PREDICTED, 1'b0, '0},
			'{"t",          1'b0, ROW_PREDICTED, 1'b0, '0},
			'{SPACE_CHAR,   1'b0, ROW_TYPED,     1'b1, '{SLOT_A, 24'd1}},
			'{"c",          1'b0, ROW_PREDICTED, 1'b0, '0},
			'{"a",          1'b0, ROW_PREDICTED, 1'b0, '0},
			'{"t",          1'b0, ROW_PREDICTED, 1'b0, '0},
			'{"x",          1'b1, ROW_TYPED,     1'b1, '{SLOT_A, 24'd2}},
			'{8'hFF,        1'b1, ROW_TYPED,     1'b0, '0},
			'{8'h00,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{8'hFF,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{8'h09,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{8'h21,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{8'h41,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{8'h7E,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{8'h80,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{8'h01,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{NEWLINE_CHAR, 1'b0, ROW_TYPED,     1'b1, '{SLOT_B, 24'd1}},
			'{8'h00,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{8'hFF,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{8'h09,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{8'h21,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{8'h41,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{8'h7E,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{8'h80,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{8'h01,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{8'h55,        1'b0, ROW_PREDICTED, 1'b0, '0},
			'{SPACE_CHAR,   1'b0, ROW_TYPED,     1'b0, '0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cfg_write(REG_KW_A, 64'h746163);
		cfg_write(REG_KW_B, 64'h01807E412109FF00);
		cfg_write(REG_KW_C, 64'h746163);
		cfg_write(REG_KW_D, 64'h746163);
		cfg_write(REG_LENGTHS, 64'h9383);
		cfg_valid <= 1'b0;

		foreach (directed_rows[r]) begin
			send_byte(directed_rows[r].ch, directed_rows[r].eot);
			scan_byte(directed_rows[r].ch, directed_rows[r].eot, hit, tally);
			if (directed_rows[r].kind == ROW_TYPED) begin
				hit = directed_rows[r].hit;
				tally = directed_rows[r].want;
			end
			if (hit)
				expected_tallies.insert(expected_tallies.size(), tally);
			sender_gap();
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			wait_drained();
			load_keywords(phase);
			quiet_sender = (phase == HOLD_PHASE || phase == QUIET_PHASE);
			quiet_receiver = (phase == QUIET_PHASE);
			// The long hold lets the output queue fill until the input stalls.
			if (phase == HOLD_PHASE)
				hold_request = 1'b1;
			phase_items = 0;
			paused = 1'b0;
			while (phase_items < ITEMS_PER_PHASE) begin
				if (phase == PAUSE_PHASE && !paused && phase_items >= ITEMS_PER_PHASE / 2) begin
					wait_drained();
					paused = 1'b1;
				end
				word.delete();
				pick = $urandom_range(0, 99);
				slot = $urandom_range(0, KEYWORD_SLOTS - 1);
				klen = kw_lengths[4*slot +: 4];
				if (pick < 75) begin
					// A keyword, exact or slightly altered.
					n = (klen >= 1 && klen <= MAX_WORD_BYTES) ? klen
						: $urandom_range(1, MAX_WORD_BYTES);
					for (int i = 0; i < n; i++)
						word.insert(word.size(), kw_text[slot][8*i +: 8]);
					if (pick >= 55) begin
						case ($urandom_range(0, 2))
							0: begin
								pos = $urandom_range(0, n - 1);
								word[pos] = word[pos] ^ (8'd1 << $urandom_range(0, 7));
							end
							1: if (n > 1)
								void'(word.pop_back());
							default: repeat ($urandom_range(1, 3))
								word.insert(word.size(), BYTE_W'($urandom_range(0, 255)));
						endcase
					end
				end else if (pick < 88) begin
					repeat ($urandom_range(1, 11))
						word.insert(word.size(), BYTE_W'($urandom_range(0, 255)));
				end
				foreach (word[i])
					send_scanned(word[i], 1'b0);
				pick = $urandom_range(0, 99);
				if (pick < 4)
					send_scanned(BYTE_W'($urandom_range(0, 255)), 1'b1);
				else if (pick < 52)
					send_scanned(SPACE_CHAR, 1'b0);
				else
					send_scanned(NEWLINE_CHAR, 1'b0);
			end
		end

		wait_drained();
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
src/kfc_pkg.sv
src/kfc_front.sv
src/kfc_queue.sv
src/kfc_back.sv
src/keyword_frequency_counter.sv
dv/keyword_frequency_counter_tb.sv
